>>> rtl/srra_pkg.sv
// Shared types and codes for the slot reuse region allocator.
`default_nettype none
package srra_pkg;

   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int BASE_W   = 14;
   localparam int SIZE_W   = 15;

   localparam logic [STATUS_W-1:0] ST_NEW        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REUSED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd6;

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [BASE_W-1:0]   base;
      logic [SIZE_W-1:0]   size;
   } res_type;

   typedef struct packed {
      logic act_we;
      logic act_val;
      logic data_we;
   } mem_we_type;

endpackage
`default_nettype wire

>>> rtl/slot_reuse_region_allocator_top.sv
// Top level of the slot reuse region allocator: slot memory, sequencer, result register.
// Release, ignored and bad size results skip the slot scan; an allocate first scans the
//   slots in use from the lowest up and stops at the first retired slot that fits.
// One request at a time: req_stall holds until the result register takes the result;
//   the scan reads one slot per cycle through the single read port of the slot memory.
// Reset clears the sequencer, slot count and bump pointer; slot memory is not cleared.
`default_nettype none
module slot_reuse_region_allocator_top #(
   parameter int MAX_SLOTS = 16,
   parameter int POOL_SIZE = 16384
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_type,
   input  wire logic [14:0]  req_request_size,
   input  wire logic [3:0]   req_slot_id,
   // response channel
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [3:0]        rsp_slot_out,
   output logic [13:0]       rsp_base_offset,
   output logic [14:0]       rsp_reserved_size
);
   import srra_pkg::*;

   // slot address, slot count and bump pointer widths
   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int PW = $clog2(POOL_SIZE + 1);

   mem_we_type          mem_we;
   logic [AW-1:0]       mem_wr_addr;
   logic [SIZE_W-1:0]   mem_wr_rsv;
   logic [PW-1:0]       mem_wr_base;
   logic [AW-1:0]       mem_rd_addr;
   logic                mem_rd_act;
   logic [SIZE_W-1:0]   mem_rd_rsv;
   logic [PW-1:0]       mem_rd_base;

   logic                res_valid;
   res_type             res;
   logic                res_ready;

   logic                rsp_valid_ff, rsp_valid_in;
   res_type             rsp_ff, rsp_in;

   srra_slot_mem #(
      .DEPTH (MAX_SLOTS),
      .AW    (AW),
      .PW    (PW)
   ) u_mem (
      .clock      (clock),
      .we         (mem_we),
      .wr_addr    (mem_wr_addr),
      .wr_rsv     (mem_wr_rsv),
      .wr_base    (mem_wr_base),
      .rd_addr    (mem_rd_addr),
      .rd_act_ff  (mem_rd_act),
      .rd_rsv_ff  (mem_rd_rsv),
      .rd_base_ff (mem_rd_base)
   );

   srra_ctrl #(
      .MAX_SLOTS (MAX_SLOTS),
      .POOL_SIZE (POOL_SIZE),
      .AW        (AW),
      .CW        (CW),
      .PW        (PW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_size    (req_request_size),
      .req_sid     (req_slot_id),
      .res_valid   (res_valid),
      .res         (res),
      .res_ready   (res_ready),
      .mem_we      (mem_we),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_rsv  (mem_wr_rsv),
      .mem_wr_base (mem_wr_base),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_act  (mem_rd_act),
      .mem_rd_rsv  (mem_rd_rsv),
      .mem_rd_base (mem_rd_base)
   );

   // The result register takes a new beat when empty or draining, so the
   // sequencer can return to idle and take the next request while a result
   // still waits downstream.
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_slot_out      = rsp_ff.slot;
   assign rsp_base_offset   = rsp_ff.base;
   assign rsp_reserved_size = rsp_ff.size;

endmodule
`default_nettype wire

>>> rtl/srra_slot_mem.sv
// Slot table storage: active-mark memory and reservation/base memory.
`default_nettype none
module srra_slot_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int PW    = 15
) (
   input  wire logic                       clock,
   input  wire srra_pkg::mem_we_type       we,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [srra_pkg::SIZE_W-1:0] wr_rsv,
   input  wire logic [PW-1:0]              wr_base,
   input  wire logic [AW-1:0]              rd_addr,
   output logic                            rd_act_ff,
   output logic [srra_pkg::SIZE_W-1:0]     rd_rsv_ff,
   output logic [PW-1:0]                   rd_base_ff
);
   import srra_pkg::*;

   logic                    act_mem  [DEPTH];
   logic [SIZE_W+PW-1:0]    data_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we.act_we) begin
         act_mem[wr_addr] <= we.act_val;
      end
      if (we.data_we) begin
         data_mem[wr_addr] <= {wr_rsv, wr_base};
      end
   end

   always_ff @(posedge clock) begin
      rd_act_ff                <= act_mem[rd_addr];
      {rd_rsv_ff, rd_base_ff}  <= data_mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/srra_ctrl.sv
// Request sequencer: decode, slot scan, bump pointer and slot count.
`default_nettype none
module srra_ctrl #(
   parameter int MAX_SLOTS = 16,
   parameter int POOL_SIZE = 16384,
   parameter int AW        = 4,
   parameter int CW        = 5,
   parameter int PW        = 15
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_type,
   input  wire logic [srra_pkg::SIZE_W-1:0] req_size,
   input  wire logic [srra_pkg::SLOT_W-1:0] req_sid,
   output logic                             res_valid,
   output srra_pkg::res_type                res,
   input  wire logic                        res_ready,
   output srra_pkg::mem_we_type             mem_we,
   output logic [AW-1:0]                    mem_wr_addr,
   output logic [srra_pkg::SIZE_W-1:0]      mem_wr_rsv,
   output logic [PW-1:0]                    mem_wr_base,
   output logic [AW-1:0]                    mem_rd_addr,
   input  wire logic                        mem_rd_act,
   input  wire logic [srra_pkg::SIZE_W-1:0] mem_rd_rsv,
   input  wire logic [PW-1:0]               mem_rd_base
);
   import srra_pkg::*;

   localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
   localparam int SW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic                type_ff, type_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [SLOT_W-1:0]   sid_ff, sid_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [PW-1:0]       pool_ff, pool_in;
   logic [CW-1:0]       iss_ff, iss_in;
   logic                ev_ff, ev_in;
   logic [AW-1:0]       ev_idx_ff, ev_idx_in;
   res_type             res_ff, res_in;

   logic [XW-1:0]       sid_x;
   logic                sid_ok;
   logic                hit;
   logic [SW-1:0]       pool_sum;
   logic                pool_over;
   logic                table_full;

   assign sid_x      = XW'(sid_ff);
   assign sid_ok     = sid_x < XW'(used_ff);
   assign hit        = ev_ff && !mem_rd_act && (mem_rd_rsv >= size_ff);
   assign pool_sum   = SW'(pool_ff) + SW'(size_ff);
   assign pool_over  = pool_sum > SW'(POOL_SIZE);
   assign table_full = used_ff == CW'(MAX_SLOTS);

   assign req_stall  = state_ff != S_IDLE;
   assign res_valid  = state_ff == S_DONE;
   assign res        = res_ff;
   assign mem_rd_addr = iss_ff[AW-1:0];
   assign mem_wr_rsv  = size_ff;
   assign mem_wr_base = pool_ff;

   always_comb begin
      state_in    = state_ff;
      type_in     = type_ff;
      size_in     = size_ff;
      sid_in      = sid_ff;
      used_in     = used_ff;
      pool_in     = pool_ff;
      iss_in      = iss_ff;
      ev_in       = 1'b0;
      ev_idx_in   = ev_idx_ff;
      res_in      = res_ff;
      mem_we      = '0;
      mem_wr_addr = used_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               type_in  = req_type;
               size_in  = req_size;
               sid_in   = req_sid;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in   = '0;
            iss_in   = '0;
            state_in = S_DONE;
            if (type_ff == REQ_RELEASE) begin
               if (sid_ok) begin
                  mem_we.act_we  = 1'b1;
                  mem_we.act_val = 1'b0;
                  mem_wr_addr    = sid_x[AW-1:0];
                  res_in.status  = ST_RELEASED;
                  res_in.slot    = sid_ff;
               end else begin
                  res_in.status  = ST_IGNORED;
               end
            end else if (size_ff == '0) begin
               res_in.status = ST_BAD_SIZE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               // lowest retired slot that still fits
               mem_we.act_we  = 1'b1;
               mem_we.act_val = 1'b1;
               mem_wr_addr    = ev_idx_ff;
               res_in.status  = ST_REUSED;
               res_in.slot    = SLOT_W'(ev_idx_ff);
               res_in.base    = BASE_W'(mem_rd_base);
               res_in.size    = mem_rd_rsv;
               state_in       = S_DONE;
            end else if (iss_ff < used_ff) begin
               ev_in     = 1'b1;
               ev_idx_in = iss_ff[AW-1:0];
               iss_in    = iss_ff + 1'b1;
            end else begin
               state_in = S_DONE;
               if (pool_over) begin
                  res_in.status = ST_POOL_FULL;
               end else if (table_full) begin
                  res_in.status = ST_TABLE_FULL;
               end else begin
                  // append at the bump pointer
                  mem_we.act_we  = 1'b1;
                  mem_we.act_val = 1'b1;
                  mem_we.data_we = 1'b1;
                  res_in.status  = ST_NEW;
                  res_in.slot    = SLOT_W'(used_ff);
                  res_in.base    = BASE_W'(pool_ff);
                  res_in.size    = size_ff;
                  pool_in        = PW'(pool_sum);
                  used_in        = used_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         pool_ff  <= '0;
         ev_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         pool_ff  <= pool_in;
         ev_ff    <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      size_ff   <= size_in;
      sid_ff    <= sid_in;
      iss_ff    <= iss_in;
      ev_idx_ff <= ev_idx_in;
      res_ff    <= res_in;
   end

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MAX_SLOTS))
      else $error("slot count beyond table depth");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      SW'(pool_ff) <= SW'(POOL_SIZE))
      else $error("bump pointer beyond pool");

   a_used_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> used_ff >= $past(used_ff))
      else $error("slot count moved back");

   a_pool_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> pool_ff >= $past(pool_ff))
      else $error("bump pointer moved back");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      mem_we.data_we |-> (!table_full && !pool_over && state_ff == S_SCAN))
      else $error("append without room");
`endif

endmodule
`default_nettype wire
